/* rtl/core/mpqs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqs_pkg
// Shared sizes, codes and types of the scanned min-priority queue.
// ----------------------------------------------------------------------------
package mpqs_pkg;

   localparam int CAPACITY     = 64;
   localparam int ID_WIDTH     = 16;
   localparam int PRIO_WIDTH   = 16;
   localparam int SEQ_WIDTH    = 32;
   localparam int IDX_WIDTH    = $clog2(CAPACITY);
   localparam int CNT_WIDTH    = $clog2(CAPACITY + 1);
   localparam int OCC_WIDTH    = 7;
   localparam int STATUS_WIDTH = 3;
   localparam int KEY_WIDTH    = PRIO_WIDTH + SEQ_WIDTH;

   typedef enum logic [1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_UPGRADE = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STS_OK           = 3'd0,
      STS_EMPTY        = 3'd1,
      STS_NOT_FOUND    = 3'd2,
      STS_LESS_URGENT  = 3'd3,
      STS_FULL         = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]   id;
      logic [PRIO_WIDTH-1:0] prio;
      logic [SEQ_WIDTH-1:0]  seq;
   } entry_type;

endpackage

/* rtl/core/min_priority_queue_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_scan
// Bounded min-priority queue kept in an unsorted entry memory.
//
// Requests arrive on req_* (valid/stall) and carry a request kind (enqueue,
// dequeue, upgrade, clear), an item id and a priority. Exactly one response
// leaves on rsp_* for each request: status, removed id, front id and
// priority, empty flag and occupancy after the request.
// Every request walks the whole entry memory, one entry per cycle through
// its single read port, tracking the most urgent entry, the runner-up, the
// most urgent entry with the request id and the lowest free slot. A final
// state writes any changed entry and the valid bits back and loads the response register.
// A new request is taken only after the previous one has been written back,
// as req_stall stays high from acceptance until the queue is idle again.
// The response sits in its own register, so the next request is accepted
// while an earlier response waits on rsp_stall; the write-back of the
// following request waits until that register is free.
// Reset empties the queue and zeroes the arrival counter; the entry memory
// itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module min_priority_queue_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [mpqs_pkg::ID_WIDTH-1:0]       req_item_id,
   input  logic [mpqs_pkg::PRIO_WIDTH-1:0]     req_priority_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mpqs_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic [mpqs_pkg::ID_WIDTH-1:0]       rsp_removed_id,
   output logic [mpqs_pkg::ID_WIDTH-1:0]       rsp_front_id,
   output logic [mpqs_pkg::PRIO_WIDTH-1:0]     rsp_front_priority,
   output logic                                rsp_is_empty,
   output logic [mpqs_pkg::OCC_WIDTH-1:0]      rsp_occupancy
);
   import mpqs_pkg::*;

   state_type              state_ff, state_in;
   logic                   req_accept, scan_on, commit;

   entry_type              mem [CAPACITY];
   entry_type              rd_data_ff;
   logic                   wr_en;
   logic [IDX_WIDTH-1:0]   wr_addr;
   entry_type              wr_data;

   logic [CAPACITY-1:0]    valid_ff, valid_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [SEQ_WIDTH-1:0]   arrival_ff, arrival_in;

   logic [IDX_WIDTH-1:0]   scan_addr_ff, scan_addr_in;
   logic                   pv_ff;
   logic                   vld_q_ff;
   logic [IDX_WIDTH-1:0]   idx_q_ff;

   req_kind_type           op_kind_ff;
   logic [ID_WIDTH-1:0]    op_id_ff;
   logic [PRIO_WIDTH-1:0]  op_prio_ff;

   logic                   best_found_ff, best_found_in;
   logic [KEY_WIDTH-1:0]   best_key_ff, best_key_in;
   logic [IDX_WIDTH-1:0]   best_idx_ff, best_idx_in;
   logic [ID_WIDTH-1:0]    best_id_ff, best_id_in;
   logic                   second_found_ff, second_found_in;
   logic [KEY_WIDTH-1:0]   second_key_ff, second_key_in;
   logic [ID_WIDTH-1:0]    second_id_ff, second_id_in;
   logic                   match_found_ff, match_found_in;
   logic [KEY_WIDTH-1:0]   match_key_ff, match_key_in;
   logic [IDX_WIDTH-1:0]   match_idx_ff, match_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_WIDTH-1:0]   free_idx_ff, free_idx_in;

   logic [KEY_WIDTH-1:0]   cur_key;
   logic [KEY_WIDTH-1:0]   cand_key;
   logic [IDX_WIDTH-1:0]   cand_idx;
   logic                   cand_wins;

   status_type             res_status;
   logic [ID_WIDTH-1:0]    res_removed;
   logic                   res_front_found;
   logic [ID_WIDTH-1:0]    res_front_id;
   logic [PRIO_WIDTH-1:0]  res_front_prio;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [ID_WIDTH-1:0]    rsp_removed_ff;
   logic [ID_WIDTH-1:0]    rsp_front_id_ff;
   logic [PRIO_WIDTH-1:0]  rsp_front_prio_ff;
   logic [CNT_WIDTH-1:0]   rsp_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_addr_ff == IDX_WIDTH'(CAPACITY - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      scan_on   = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SCAN: begin
            scan_on = 1'b1;
         end
         ST_DRAIN: begin
            scan_on = 1'b0;
         end
         ST_FINISH: begin
            commit = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign req_accept   = req_valid && !req_stall;
   assign scan_addr_in = req_accept ? '0 : (scan_on ? scan_addr_ff + 1'b1 : scan_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= scan_on;
      end
      scan_addr_ff <= scan_addr_in;
      vld_q_ff     <= valid_ff[scan_addr_ff];
      idx_q_ff     <= scan_addr_ff;
      if (req_accept) begin
         op_kind_ff <= req_kind_type'(req_type);
         op_id_ff   <= req_item_id;
         op_prio_ff <= req_priority_req;
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[scan_addr_ff];
   end

   // scan accumulation
   assign cur_key = {rd_data_ff.prio, rd_data_ff.seq};

   always_comb begin
      best_found_in   = best_found_ff;
      best_key_in     = best_key_ff;
      best_idx_in     = best_idx_ff;
      best_id_in      = best_id_ff;
      second_found_in = second_found_ff;
      second_key_in   = second_key_ff;
      second_id_in    = second_id_ff;
      match_found_in  = match_found_ff;
      match_key_in    = match_key_ff;
      match_idx_in    = match_idx_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      if (req_accept) begin
         best_found_in   = 1'b0;
         second_found_in = 1'b0;
         match_found_in  = 1'b0;
         free_found_in   = 1'b0;
      end else if (pv_ff) begin
         if (!vld_q_ff) begin
            if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_q_ff;
            end
         end else begin
            if (!best_found_ff || cur_key < best_key_ff) begin
               second_found_in = best_found_ff;
               second_key_in   = best_key_ff;
               second_id_in    = best_id_ff;
               best_found_in   = 1'b1;
               best_key_in     = cur_key;
               best_idx_in     = idx_q_ff;
               best_id_in      = rd_data_ff.id;
            end else if (!second_found_ff || cur_key < second_key_ff) begin
               second_found_in = 1'b1;
               second_key_in   = cur_key;
               second_id_in    = rd_data_ff.id;
            end
            if (rd_data_ff.id == op_id_ff && (!match_found_ff || cur_key < match_key_ff)) begin
               match_found_in = 1'b1;
               match_key_in   = cur_key;
               match_idx_in   = idx_q_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      best_found_ff   <= best_found_in;
      best_key_ff     <= best_key_in;
      best_idx_ff     <= best_idx_in;
      best_id_ff      <= best_id_in;
      second_found_ff <= second_found_in;
      second_key_ff   <= second_key_in;
      second_id_ff    <= second_id_in;
      match_found_ff  <= match_found_in;
      match_key_ff    <= match_key_in;
      match_idx_ff    <= match_idx_in;
      free_found_ff   <= free_found_in;
      free_idx_ff     <= free_idx_in;
   end

   // new or upgraded entry against the scanned front, lower slot wins a full tie
   always_comb begin
      if (op_kind_ff == REQ_ENQUEUE) begin
         cand_key = {op_prio_ff, arrival_ff};
         cand_idx = free_idx_ff;
      end else begin
         cand_key = {op_prio_ff, match_key_ff[SEQ_WIDTH-1:0]};
         cand_idx = match_idx_ff;
      end
      cand_wins = !best_found_ff || cand_key < best_key_ff ||
                  (cand_key == best_key_ff && cand_idx < best_idx_ff);
   end

   // request outcome
   always_comb begin
      res_status      = STS_OK;
      res_removed     = '0;
      res_front_found = best_found_ff;
      res_front_id    = best_id_ff;
      res_front_prio  = best_key_ff[KEY_WIDTH-1 -: PRIO_WIDTH];
      valid_in        = valid_ff;
      count_in        = count_ff;
      arrival_in      = arrival_ff;
      wr_en           = 1'b0;
      wr_addr         = free_idx_ff;
      wr_data         = '{id: op_id_ff, prio: op_prio_ff, seq: arrival_ff};
      case (op_kind_ff)
         REQ_ENQUEUE: begin
            if (!free_found_ff) begin
               res_status = STS_FULL;
            end else begin
               wr_en                 = commit;
               valid_in[free_idx_ff] = 1'b1;
               count_in              = count_ff + 1'b1;
               arrival_in            = arrival_ff + 1'b1;
               if (cand_wins) begin
                  res_front_found = 1'b1;
                  res_front_id    = op_id_ff;
                  res_front_prio  = op_prio_ff;
               end
            end
         end
         REQ_DEQUEUE: begin
            if (!best_found_ff) begin
               res_status = STS_EMPTY;
            end else begin
               res_removed           = best_id_ff;
               valid_in[best_idx_ff] = 1'b0;
               count_in              = count_ff - 1'b1;
               res_front_found       = second_found_ff;
               res_front_id          = second_id_ff;
               res_front_prio        = second_key_ff[KEY_WIDTH-1 -: PRIO_WIDTH];
            end
         end
         REQ_UPGRADE: begin
            if (count_ff == '0) begin
               res_status = STS_EMPTY;
            end else if (!match_found_ff) begin
               res_status = STS_NOT_FOUND;
            end else if (match_key_ff[KEY_WIDTH-1 -: PRIO_WIDTH] < op_prio_ff) begin
               res_status = STS_LESS_URGENT;
            end else begin
               wr_en   = commit;
               wr_addr = match_idx_ff;
               wr_data = '{id: op_id_ff, prio: op_prio_ff,
                           seq: match_key_ff[SEQ_WIDTH-1:0]};
               if (cand_wins) begin
                  res_front_found = 1'b1;
                  res_front_id    = op_id_ff;
                  res_front_prio  = op_prio_ff;
               end
            end
         end
         REQ_CLEAR: begin
            valid_in        = '0;
            count_in        = '0;
            res_front_found = 1'b0;
         end
         default: begin
            res_status = STS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         arrival_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            valid_ff   <= valid_in;
            count_ff   <= count_in;
            arrival_ff <= arrival_in;
         end
         if (commit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (commit) begin
         rsp_status_ff     <= res_status;
         rsp_removed_ff    <= res_removed;
         rsp_front_id_ff   <= res_front_found ? res_front_id : '0;
         rsp_front_prio_ff <= res_front_found ? res_front_prio : '0;
         rsp_count_ff      <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_id     = rsp_removed_ff;
   assign rsp_front_id       = rsp_front_id_ff;
   assign rsp_front_priority = rsp_front_prio_ff;
   assign rsp_is_empty       = (rsp_count_ff == '0);
   assign rsp_occupancy      = OCC_WIDTH'(rsp_count_ff);

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(CAPACITY))
      else $error("occupancy above capacity");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_WIDTH'($countones(valid_ff)))
      else $error("occupancy out of step with valid bits");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_SCAN && scan_addr_ff == '0)
      else $error("accepted request did not start a scan");

   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STS_FULL |-> rsp_count_ff == CNT_WIDTH'(CAPACITY))
      else $error("full status with free slots");

endmodule

/* bench/min_priority_queue_scan_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_scan_test
// Self-checking bench for the scanned min-priority queue.
//
// A short directed sequence covers the empty, missing-id, less-urgent, equal
// upgrade, tie and clear cases. It is followed by about 2000 random requests
// in fill, drain and mixed stretches, so the table fills and empties many
// times. A scoreboard keeps its own copy of the table, predicts the response
// for every accepted request and checks the responses in order.
// ----------------------------------------------------------------------------
module min_priority_queue_scan_test;
   import mpqs_pkg::*;

   localparam int RANDOM_ITEMS   = 2000;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 4 * CAPACITY;

   typedef struct packed {
      status_type            status;
      logic [ID_WIDTH-1:0]   removed_id;
      logic [ID_WIDTH-1:0]   front_id;
      logic [PRIO_WIDTH-1:0] front_priority;
      logic                  is_empty;
      logic [OCC_WIDTH-1:0]  occupancy;
   } queue_result_type;

   class pq_scoreboard_type;
      bit                  slot_used [CAPACITY];
      bit [ID_WIDTH-1:0]   slot_id   [CAPACITY];
      bit [PRIO_WIDTH-1:0] slot_prio [CAPACITY];
      bit [SEQ_WIDTH-1:0]  slot_seq  [CAPACITY];
      bit [SEQ_WIDTH-1:0]  arrivals;
      int                  held;
      int                  errors;
      queue_result_type    pending_rsp [$];

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         arrivals = '0;
         held     = 0;
         errors   = 0;
      endfunction

      function bit ahead_of(int a, int b);
         if (slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
         if (slot_seq[a] != slot_seq[b]) return slot_seq[a] < slot_seq[b];
         return a < b;
      endfunction

      // most urgent held entry, optionally only among those with one id
      function int most_urgent(bit match_id, bit [ID_WIDTH-1:0] id);
         int best;
         best = -1;
         for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] && (!match_id || slot_id[i] == id) &&
                (best < 0 || ahead_of(i, best)))
               best = i;
         end
         return best;
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      function void note_request(req_kind_type kind, bit [ID_WIDTH-1:0] id,
                                 bit [PRIO_WIDTH-1:0] prio);
         queue_result_type r;
         int               k;
         r = '0;
         r.status = STS_OK;
         case (kind)
            REQ_ENQUEUE: begin
               k = -1;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (!slot_used[i] && k < 0) k = i;
               end
               if (k < 0) begin
                  r.status = STS_FULL;
               end else begin
                  slot_used[k] = 1'b1;
                  slot_id[k]   = id;
                  slot_prio[k] = prio;
                  slot_seq[k]  = arrivals;
                  arrivals     = arrivals + 1;
                  held++;
               end
            end
            REQ_DEQUEUE: begin
               k = most_urgent(1'b0, '0);
               if (k < 0) begin
                  r.status = STS_EMPTY;
               end else begin
                  r.removed_id = slot_id[k];
                  slot_used[k] = 1'b0;
                  held--;
               end
            end
            REQ_UPGRADE: begin
               if (held == 0) begin
                  r.status = STS_EMPTY;
               end else begin
                  k = most_urgent(1'b1, id);
                  if (k < 0) r.status = STS_NOT_FOUND;
                  else if (slot_prio[k] < prio) r.status = STS_LESS_URGENT;
                  else slot_prio[k] = prio;
               end
            end
            default: begin
               foreach (slot_used[i]) slot_used[i] = 1'b0;
               held = 0;
            end
         endcase
         k = most_urgent(1'b0, '0);
         if (k >= 0) begin
            r.front_id       = slot_id[k];
            r.front_priority = slot_prio[k];
         end
         r.is_empty  = (held == 0);
         r.occupancy = held[OCC_WIDTH-1:0];
         pending_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(logic [STATUS_WIDTH-1:0] status,
                                   logic [ID_WIDTH-1:0] removed_id,
                                   logic [ID_WIDTH-1:0] front_id,
                                   logic [PRIO_WIDTH-1:0] front_priority,
                                   logic is_empty, logic [OCC_WIDTH-1:0] occupancy);
         queue_result_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with no request outstanding, status %0d", $time, status);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         compare_field("status", want.status, status);
         compare_field("removed_id", want.removed_id, removed_id);
         compare_field("front_id", want.front_id, front_id);
         compare_field("front_priority", want.front_priority, front_priority);
         compare_field("is_empty", want.is_empty, is_empty);
         compare_field("occupancy", want.occupancy, occupancy);
      endfunction
   endclass

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_type         = REQ_ENQUEUE;
   logic [ID_WIDTH-1:0]     req_item_id      = '0;
   logic [PRIO_WIDTH-1:0]   req_priority_req = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [ID_WIDTH-1:0]     rsp_removed_id;
   logic [ID_WIDTH-1:0]     rsp_front_id;
   logic [PRIO_WIDTH-1:0]   rsp_front_priority;
   logic                    rsp_is_empty;
   logic [OCC_WIDTH-1:0]    rsp_occupancy;

   int                send_idle_pct = 31;
   int                recv_idle_pct = 53;
   pq_scoreboard_type ledger        = new();

   min_priority_queue_scan dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_item_id        (req_item_id),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_removed_id     (rsp_removed_id),
      .rsp_front_id       (rsp_front_id),
      .rsp_front_priority (rsp_front_priority),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_occupancy      (rsp_occupancy)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            ledger.note_request(req_kind_type'(req_type), req_item_id, req_priority_req);
         if (rsp_valid && !rsp_stall)
            ledger.check_response(rsp_status, rsp_removed_id, rsp_front_id,
                                  rsp_front_priority, rsp_is_empty, rsp_occupancy);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(req_kind_type kind, bit [ID_WIDTH-1:0] id,
                               bit [PRIO_WIDTH-1:0] prio);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_item_id      <= id;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      do @(negedge clock); while (ledger.pending() != 0);
   endtask

   function automatic bit [ID_WIDTH-1:0] pick_id();
      bit [ID_WIDTH-1:0] id_pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                         16'hFFFF, 16'h8000, 16'h5A5A, 16'h00FF};
      if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, 7)];
      return ID_WIDTH'($urandom);
   endfunction

   function automatic bit [PRIO_WIDTH-1:0] pick_prio();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return PRIO_WIDTH'($urandom_range(0, 7));
      if (roll == 4) return $urandom_range(0, 1) ? '1 : '0;
      return PRIO_WIDTH'($urandom);
   endfunction

   initial begin : stimulus
      int           mode;
      int           roll;
      int           enq_cut;
      int           deq_cut;
      int           upg_cut;
      req_kind_type kind;

      mode = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue, then ties, duplicate ids and every upgrade outcome
      send_request(REQ_DEQUEUE, 16'h0000, 16'h0000);
      send_request(REQ_UPGRADE, 16'h0000, 16'h0000);
      send_request(REQ_CLEAR,   16'h0000, 16'h0000);
      send_request(REQ_ENQUEUE, 16'hFFFF, 16'hFFFF);
      send_request(REQ_ENQUEUE, 16'h0000, 16'h0000);
      send_request(REQ_ENQUEUE, 16'h0001, 16'h0000);
      send_request(REQ_ENQUEUE, 16'h0001, 16'h0064);
      send_request(REQ_UPGRADE, 16'h1234, 16'h0000);
      send_request(REQ_UPGRADE, 16'h0001, 16'h00C8);
      send_request(REQ_UPGRADE, 16'hFFFF, 16'hFFFF);
      send_request(REQ_UPGRADE, 16'hFFFF, 16'h0000);
      send_request(REQ_DEQUEUE, 16'hFFFF, 16'hFFFF);
      send_request(REQ_DEQUEUE, 16'h0000, 16'h0000);
      send_request(REQ_UPGRADE, 16'h0001, 16'h0000);
      send_request(REQ_DEQUEUE, 16'h0000, 16'h0000);
      send_request(REQ_DEQUEUE, 16'h0000, 16'h0000);
      send_request(REQ_DEQUEUE, 16'h0000, 16'h0000);
      send_request(REQ_ENQUEUE, 16'h0005, 16'h0007);
      send_request(REQ_ENQUEUE, 16'h0006, 16'h0007);
      send_request(REQ_CLEAR,   16'hFFFF, 16'hFFFF);
      send_request(REQ_ENQUEUE, 16'h0007, 16'h0003);
      send_request(REQ_DEQUEUE, 16'h0000, 16'h0000);
      drain_requests();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            drain_requests();
            send_idle_pct = 53;
            recv_idle_pct = 31;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            drain_requests();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n % 150 == 0) mode = $urandom_range(0, 2);
         // fill, drain and mixed stretches
         case (mode)
            0: begin enq_cut = 75; deq_cut = 85; upg_cut = 98; end
            1: begin enq_cut = 15; deq_cut = 80; upg_cut = 98; end
            default: begin enq_cut = 40; deq_cut = 70; upg_cut = 98; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < enq_cut) kind = REQ_ENQUEUE;
         else if (roll < deq_cut) kind = REQ_DEQUEUE;
         else if (roll < upg_cut) kind = REQ_UPGRADE;
         else kind = REQ_CLEAR;
         send_request(kind, pick_id(), pick_prio());
      end

      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
